@@ hdl/priority_interrupt_controller_defines.svh @@
// ----------------------------------------------------------------------------
// priority interrupt controller assertion macros
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS
// property checked at every rising clock edge outside reset
`define PIC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
// condition that must never hold
`define PIC_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `PIC_ASSERT(lbl, clk, rstn, !(cond))
`else
`define PIC_ASSERT(lbl, clk, rstn, prop)
`define PIC_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

@@ hdl/pic_pkg.sv @@
// ----------------------------------------------------------------------------
// pic_pkg
// types and constants of the priority interrupt controller
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int NumLevels = 7;
  localparam int LvlW      = 3;
  localparam int OpW       = 18;
  localparam int FwW       = 36;
  localparam int StatusW   = 25;
  localparam int LowStatW  = 18;

  // control word bit positions
  localparam int CwParityLsb = 15;
  localparam int CwDrop      = 13;
  localparam int CwClear     = 12;
  localparam int CwReq       = 11;
  localparam int CwLvlOn     = 10;
  localparam int CwLvlOff    = 9;
  localparam int CwOff       = 8;
  localparam int CwOn        = 7;

  typedef logic [NumLevels-1:0] pic_mask_t;
  typedef logic [LvlW-1:0]      pic_level_t;

  typedef enum logic [2:0] {
    ACT_WRITE     = 3'd0,
    ACT_READ      = 3'd1,
    ACT_SKIP_ZERO = 3'd2,
    ACT_SKIP_ONE  = 3'd3,
    ACT_IO_REQ    = 3'd4,
    ACT_DISMISS   = 3'd5,
    ACT_TAKEN     = 3'd6,
    ACT_EVAL      = 3'd7
  } pic_action_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } pic_state_e;

  typedef struct packed {
    pic_action_e      action;
    logic [OpW-1:0]   operand;
    pic_level_t       channel;
    logic [FwW-1:0]   function_word_in;
    logic             apr_pending;
    pic_level_t       apr_level;
  } pic_item_t;

  typedef struct packed {
    pic_level_t         granted_level;
    logic [StatusW-1:0] status_word;
    logic               skip;
    logic [FwW-1:0]     function_word_out;
  } pic_result_t;

  typedef struct packed {
    logic load;
    logic exec;
  } pic_cmd_t;

  function automatic pic_mask_t level_bit(pic_level_t lvl);
    pic_mask_t b;
    b = '0;
    if (lvl != '0 && lvl <= LvlW'(NumLevels)) begin
      b = NumLevels'(1) << (LvlW'(NumLevels) - lvl);
    end
    return b;
  endfunction

  function automatic pic_level_t top_level(pic_mask_t m);
    pic_level_t t;
    t = '0;
    for (int i = NumLevels; i >= 1; i--) begin
      if (m[NumLevels-i]) t = LvlW'(i);
    end
    return t;
  endfunction

endpackage

@@ hdl/pic_ctrl.sv @@
// ----------------------------------------------------------------------------
// pic_ctrl
// sequencer: captures a request, runs the execute state, strobes the result
// ----------------------------------------------------------------------------
module pic_ctrl import pic_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     result_valid_o,
  output pic_cmd_t cmd_o
);

  pic_state_e state_q, state_d;
  logic       valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        busy       = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.exec;
    end
  end

  assign result_valid_o = valid_q;

endmodule

@@ hdl/pic_datapath.sv @@
// ----------------------------------------------------------------------------
// pic_datapath
// request masks, grant evaluation, function word store and result register
// ----------------------------------------------------------------------------
module pic_datapath import pic_pkg::*; #(
  parameter int WORD_BITS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pic_cmd_t    cmd_i,
  input  pic_item_t   item_i,
  output pic_result_t result_o
);

  localparam int FwBits = (WORD_BITS < FwW) ? WORD_BITS : FwW;

  pic_item_t item_q;

  logic         on_q, on_d;
  logic [2:0]   par_q, par_d;
  pic_mask_t    prog_q, prog_d;
  pic_mask_t    io_q, io_d;
  pic_mask_t    act_q, act_d;
  pic_mask_t    en_q, en_d;
  pic_level_t   grant_q, grant_d;

  logic [FwBits-1:0] fw_mem_q [1:NumLevels];
  logic              fw_we;
  pic_level_t        fw_wa;
  logic [FwBits-1:0] fw_wd;

  pic_mask_t             sel;
  pic_mask_t             apr_req;
  pic_level_t            req_lvl;
  pic_level_t            act_lvl;
  logic                  do_eval;
  logic                  skip_d;
  logic [LowStatW-1:0]   low_stat;
  logic [OpW-1:0]        op;
  pic_result_t           res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
  end

  assign op       = item_q.operand;
  assign sel      = op[NumLevels-1:0];
  assign low_stat = {par_q, act_q, on_q, en_q};
  assign do_eval  = !(item_q.action inside {ACT_READ, ACT_SKIP_ZERO, ACT_SKIP_ONE});

  always_comb begin
    on_d    = on_q;
    par_d   = par_q;
    prog_d  = prog_q;
    io_d    = io_q;
    act_d   = act_q;
    en_d    = en_q;
    grant_d = grant_q;
    skip_d  = 1'b0;
    fw_we   = 1'b0;
    fw_wa   = item_q.channel;
    fw_wd   = item_q.function_word_in[FwBits-1:0];
    apr_req = '0;
    req_lvl = '0;
    act_lvl = '0;
    unique case (item_q.action)
      ACT_WRITE: begin
        if (op[CwClear]) begin
          on_d   = 1'b0;
          prog_d = '0;
          act_d  = '0;
          en_d   = '0;
        end
        par_d = op[CwParityLsb +: 3];
        if (op[CwOn]) on_d = 1'b1;
        if (op[CwOff]) on_d = 1'b0;
        if (op[CwReq]) prog_d = prog_d | sel;
        if (op[CwDrop]) prog_d = prog_d & ~sel;
        if (op[CwLvlOn]) en_d = en_d | sel;
        if (op[CwLvlOff]) en_d = en_d & ~sel;
      end
      ACT_READ: begin
        skip_d = 1'b0;
      end
      ACT_SKIP_ZERO: begin
        skip_d = (low_stat & op) == '0;
      end
      ACT_SKIP_ONE: begin
        skip_d = (low_stat & op) != '0;
      end
      ACT_IO_REQ: begin
        if (item_q.channel != '0 && item_q.channel <= LvlW'(NumLevels)) begin
          io_d  = io_q | level_bit(item_q.channel);
          fw_we = 1'b1;
        end
      end
      ACT_DISMISS: begin
        act_d = act_q & ~level_bit(top_level(act_q));
      end
      ACT_TAKEN: begin
        if (grant_q != '0) begin
          fw_we = 1'b1;
          fw_wa = grant_q;
          fw_wd = '0;
          act_d = act_q | level_bit(grant_q);
        end
      end
      ACT_EVAL: begin
        skip_d = 1'b0;
      end
      default: begin
        skip_d = 1'b0;
      end
    endcase

    if (do_eval) begin
      grant_d = '0;
      if (on_d) begin
        apr_req = item_q.apr_pending ? level_bit(item_q.apr_level) : '0;
        req_lvl = top_level((apr_req | io_d | prog_d) & en_d);
        act_lvl = top_level(act_d);
        if (act_lvl == '0 || req_lvl < act_lvl) begin
          io_d    = io_d & ~level_bit(req_lvl);
          grant_d = req_lvl;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= 1'b0;
      par_q   <= '0;
      prog_q  <= '0;
      io_q    <= '0;
      act_q   <= '0;
      en_q    <= '0;
      grant_q <= '0;
    end else if (cmd_i.exec) begin
      on_q    <= on_d;
      par_q   <= par_d;
      prog_q  <= prog_d;
      io_q    <= io_d;
      act_q   <= act_d;
      en_q    <= en_d;
      grant_q <= grant_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 1; i <= NumLevels; i++) fw_mem_q[i] <= '0;
    end else if (cmd_i.exec && fw_we) begin
      fw_mem_q[fw_wa] <= fw_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      res_q.granted_level <= grant_d;
      res_q.status_word   <= {prog_d, par_d, act_d, on_d, en_d};
      res_q.skip          <= skip_d;
      if (item_q.action == ACT_TAKEN && grant_q != '0) begin
        res_q.function_word_out <= FwW'(fw_mem_q[grant_q]);
      end else begin
        res_q.function_word_out <= '0;
      end
    end
  end

  assign result_o = res_q;

endmodule

@@ hdl/priority_interrupt_controller.sv @@
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// seven-level priority interrupt controller with masks and function words
// ----------------------------------------------------------------------------
// Busy is high for the one execute cycle that follows the accepting edge,
// and the result appears on result_o with result_valid_o high for exactly
// one cycle after that, so a new request can be accepted in the same cycle
// that the previous result is shown. A request passes through the input
// capture register followed by the single execute step of the mask and
// priority logic. The receiver cannot stall: result_valid_o is not held,
// though result_o keeps its value until the next execute step.
module priority_interrupt_controller import pic_pkg::*; #(
  parameter int WORD_BITS = 36
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pic_item_t   item_i,
  output logic        result_valid_o,
  output pic_result_t result_o
);

`include "priority_interrupt_controller_defines.svh"

  pic_cmd_t cmd;
  logic     grant_shown;

  pic_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  pic_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .result_o (result_o)
  );

  assign grant_shown = result_valid_o && (result_o.granted_level != '0);

  `PIC_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `PIC_ASSERT(a_busy_result, clk_i, rst_ni, busy |=> (result_valid_o && !busy))
  `PIC_ASSERT_NEVER(a_valid_busy, clk_i, rst_ni, result_valid_o && busy)
  `PIC_ASSERT(a_grant_on, clk_i, rst_ni, grant_shown |-> result_o.status_word[CwOn])

endmodule
